/* hdl/bb3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared constants, codes and types of the 3x3 box blur stream.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int MAX_HEIGHT        = 4096;

  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 13;
  localparam int ROW_W       = 12;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1024;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam int NUM_CH   = 3;
  localparam int CH_W     = 8;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  localparam int SUM_W       = 12;
  localparam int COUNT_W     = 4;
  localparam int MAX_RESULTS = 2;
  localparam int RES_DEPTH   = 8;
  localparam int RES_PTR_W   = 3;
  localparam int RES_CNT_W   = 4;

  typedef logic [NUM_CH-1:0][CH_W-1:0] bb3_rgb_t;

  typedef struct packed {
    bb3_rgb_t older;
    bb3_rgb_t newer;
  } bb3_entry_t;

  typedef struct packed {
    logic       drain;
    logic       first;
    logic [2:0] rv;
    logic [2:0] cv;
    logic       cvb0;
    logic       emit_a;
    logic       emit_b;
    logic       col0;
  } bb3_ctrl_t;

  typedef struct packed {
    logic [NUM_CH-1:0][SUM_W-1:0] sum;
    logic [COUNT_W-1:0]           count;
    logic                         last;
  } bb3_sum_t;

  typedef struct packed {
    bb3_rgb_t mean;
    logic     last;
  } bb3_res_t;

endpackage

/* hdl/bb3_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_if
// Stream interfaces of the box blur: pixel input, result output and the
// configuration write channel.
// ----------------------------------------------------------------------------
interface bb3_pix_if import bb3_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            operation;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, operation, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

interface bb3_res_if import bb3_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            last_of_run;

  modport source (output valid, red_out, green_out, blue_out, last_of_run, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, last_of_run, output ready);
endinterface

interface bb3_cfg_if import bb3_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/bb3_line_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_line_store
// Line memory holding the two previous rows of each column, one read and one
// write port, registered read data.
// ----------------------------------------------------------------------------
module bb3_line_store import bb3_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output bb3_entry_t               rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  bb3_entry_t               wr_data
);

  bb3_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/bb3_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_window
// Read-modify-write stage of the line memory with forwarding, the 3x3 window
// and the masked neighborhood sums of up to two results per beat.
// ----------------------------------------------------------------------------
module bb3_window import bb3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s0_valid,
  input  bb3_ctrl_t                    s0_ctrl,
  input  logic [$clog2(MAX_WIDTH)-1:0] s0_addr,
  input  bb3_rgb_t                     s0_pixel,
  input  bb3_entry_t                   rd_data,
  output logic                         wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  output bb3_entry_t                   wr_data,
  output logic [MAX_RESULTS-1:0]       s2_valid,
  output bb3_sum_t                     s2_slot [MAX_RESULTS]
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic          s1_valid;
  bb3_ctrl_t     ctrl;
  logic [AW-1:0] addr;
  bb3_rgb_t      pixel;
  logic          hit;
  bb3_entry_t    fwd;
  bb3_entry_t    rd_eff;
  bb3_entry_t    col0_save;

  bb3_rgb_t win  [3][3];
  bb3_rgb_t nwin [3][3];

  logic [9:0]               cs [3][NUM_CH];
  logic [NUM_CH-1:0][SUM_W-1:0] sum_a;
  logic [NUM_CH-1:0][SUM_W-1:0] sum_b;
  logic [COUNT_W-1:0]       n_rows;
  logic [COUNT_W-1:0]       n_cols;
  logic [COUNT_W-1:0]       cnt_a;
  logic [COUNT_W-1:0]       cnt_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    ctrl  <= s0_ctrl;
    addr  <= s0_addr;
    pixel <= s0_pixel;
    hit   <= wr_en && (wr_addr == s0_addr);
    fwd   <= wr_data;
  end

  assign rd_eff  = hit ? fwd : rd_data;
  assign wr_en   = s1_valid && !ctrl.drain;
  assign wr_addr = addr;
  assign wr_data = {rd_eff.newer, pixel};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nwin[i][0] = win[i][1];
      nwin[i][1] = win[i][2];
    end
    nwin[0][2] = rd_eff.older;
    nwin[1][2] = rd_eff.newer;
    nwin[2][2] = pixel;
    if (ctrl.drain && ctrl.first) begin
      nwin[0][1] = col0_save.older;
      nwin[1][1] = col0_save.newer;
      nwin[2][1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win <= nwin;
      if (!ctrl.drain && ctrl.col0) begin
        col0_save <= wr_data;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        cs[j][ch] = 10'd0;
        for (int i = 0; i < 3; i++) begin
          if (ctrl.rv[i]) begin
            cs[j][ch] = cs[j][ch] + 10'(nwin[i][j][ch]);
          end
        end
      end
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_a[ch] = (ctrl.cv[0] ? SUM_W'(cs[0][ch]) : '0)
                + (ctrl.cv[1] ? SUM_W'(cs[1][ch]) : '0)
                + (ctrl.cv[2] ? SUM_W'(cs[2][ch]) : '0);
      sum_b[ch] = (ctrl.cvb0 ? SUM_W'(cs[1][ch]) : '0) + SUM_W'(cs[2][ch]);
    end
    n_rows = COUNT_W'($countones(ctrl.rv));
    n_cols = COUNT_W'($countones(ctrl.cv));
    cnt_a  = n_rows * n_cols;
    cnt_b  = n_rows * (ctrl.cvb0 ? COUNT_W'(2) : COUNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= '0;
    end else if (s1_valid) begin
      s2_valid <= ctrl.emit_a ? {ctrl.emit_b, 1'b1} : {1'b0, ctrl.emit_b};
    end else begin
      s2_valid <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_a) begin
      s2_slot[0] <= '{sum: sum_a, count: cnt_a, last: !ctrl.emit_b};
    end else begin
      s2_slot[0] <= '{sum: sum_b, count: cnt_b, last: 1'b1};
    end
    s2_slot[1] <= '{sum: sum_b, count: cnt_b, last: 1'b1};
  end

  a_slot_order: assert property (@(posedge clk) disable iff (rst)
    s2_valid[1] |-> s2_valid[0])
    else $error("second result slot valid without the first");

  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && hit) |-> $past(wr_en))
    else $error("forwarding taken without a write in the previous cycle");

endmodule

/* hdl/bb3_divide.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_divide
// Rounded mean of each result slot: (2*sum + count) / (2*count), exact by a
// multiplication with a scaled reciprocal of the small divisor.
// ----------------------------------------------------------------------------
module bb3_divide import bb3_pkg::*; (
  input  bb3_sum_t slot [MAX_RESULTS],
  output bb3_res_t res  [MAX_RESULTS]
);

  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 18;
  localparam int NUM_W       = SUM_W + 1;
  localparam int PROD_W      = NUM_W + RECIP_W;

  function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] count);
    logic [RECIP_W-1:0] m;
    case (count)
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = 18'd131072;
    endcase
    return m;
  endfunction

  logic [NUM_W-1:0]  num  [MAX_RESULTS][NUM_CH];
  logic [PROD_W-1:0] prod [MAX_RESULTS][NUM_CH];

  always_comb begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        num[k][ch]  = {slot[k].sum[ch], 1'b0} + NUM_W'(slot[k].count);
        prod[k][ch] = PROD_W'(num[k][ch]) * PROD_W'(recip(slot[k].count));
        res[k].mean[ch] = prod[k][ch][RECIP_SHIFT +: CH_W];
      end
      res[k].last = slot[k].last;
    end
  end

endmodule

/* hdl/bb3_result_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_result_fifo
// Result queue that takes up to two results per cycle and hands out one
// result per beat.
// ----------------------------------------------------------------------------
module bb3_result_fifo import bb3_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [MAX_RESULTS-1:0] push,
  input  bb3_res_t               din [MAX_RESULTS],
  output logic                   out_valid,
  input  logic                   out_ready,
  output bb3_res_t               dout
);

  bb3_res_t               mem [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr;
  logic [RES_PTR_W-1:0]   rd_ptr;
  logic [RES_CNT_W-1:0]   count;
  logic [RES_CNT_W-1:0]   n_push;
  logic                   pop;

  assign out_valid = count != '0;
  assign dout      = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign n_push    = RES_CNT_W'(push[0]) + RES_CNT_W'(push[1]);

  always_ff @(posedge clk) begin
    if (push[0]) begin
      mem[wr_ptr] <= din[0];
    end
    if (push[1]) begin
      mem[wr_ptr + RES_PTR_W'(1)] <= din[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[RES_PTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
      count <= count + n_push - RES_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push[1] |-> push[0])
    else $error("second result pushed without the first");

endmodule

/* hdl/box_blur_3x3_stream.sv */
`timescale 1ns / 1ps
// Path: a result passes the window input registers, the sum registers and the result queue.
// Throughput: one input beat per cycle; a row-end item gives two results and the first
// item of the next row none, so the input is held back only while results stall.
// Reset: synchronous; clears counters and queue, sets credits to the queue depth, loads width and height 1024.
// The line memory is not cleared; values read from unwritten entries are masked out of the sums.
// ----------------------------------------------------------------------------
// box_blur_3x3_stream
// 3x3 box blur over an RGB raster stream with edge-aware divisors, row-end
// results and a flush drain of the last row.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream import bb3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  bb3_pix_if.sink  pixels,
  bb3_res_if.source results,
  bb3_cfg_if.sink  cfg
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (WW > WIDTH_W) ? WW : WIDTH_W;

  logic [WIDTH_W-1:0]   image_width;
  logic [HEIGHT_W-1:0]  image_height;
  logic [AW-1:0]        col;
  logic [ROW_W-1:0]     row;
  logic [AW-1:0]        drain_pos;
  logic                 draining;
  logic [RES_CNT_W-1:0] credits;

  logic [CMP_W-1:0]    width_ext;
  logic [WW-1:0]       width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic [WW-1:0]       col_p1;
  logic [HEIGHT_W-1:0] row_p1;
  logic [WW-1:0]       drain_p1;
  logic                row_end;
  logic                frame_end;
  logic                drain_end;

  logic       accept;
  logic       is_pix;
  logic       is_flush;
  logic [1:0] nres;
  logic       pop;

  logic          s0_valid;
  bb3_ctrl_t     s0_ctrl;
  logic [AW-1:0] s0_addr;
  bb3_rgb_t      s0_pixel;

  bb3_entry_t rd_data;
  logic       wr_en;
  logic [AW-1:0] wr_addr;
  bb3_entry_t wr_data;

  logic [MAX_RESULTS-1:0] s2_valid;
  bb3_sum_t               s2_slot [MAX_RESULTS];
  bb3_res_t               res     [MAX_RESULTS];
  bb3_res_t               head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_IMAGE_WIDTH:  image_width  <= cfg.data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg.data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign width_ext = CMP_W'(image_width);

  always_comb begin
    if (width_ext == '0) begin
      width_eff = WW'(1);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(width_ext);
    end
    if (image_height == '0) begin
      height_eff = HEIGHT_W'(1);
    end else if (image_height > HEIGHT_W'(MAX_HEIGHT)) begin
      height_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      height_eff = image_height;
    end
  end

  assign col_p1    = WW'(col) + WW'(1);
  assign row_p1    = HEIGHT_W'(row) + HEIGHT_W'(1);
  assign drain_p1  = WW'(drain_pos) + WW'(1);
  assign row_end   = col_p1 >= width_eff;
  assign frame_end = row_p1 >= height_eff;
  assign drain_end = drain_p1 >= width_eff;

  assign pixels.ready = credits >= RES_CNT_W'(MAX_RESULTS);
  assign accept       = pixels.valid && pixels.ready;
  assign is_pix       = !draining && (pixels.operation == OP_PIXEL);
  assign is_flush     = draining && (pixels.operation == OP_FLUSH);
  assign s0_valid     = accept && (is_pix || is_flush);
  assign s0_addr      = draining ? drain_p1[AW-1:0] : col;

  assign s0_pixel[CH_RED]   = pixels.red_in;
  assign s0_pixel[CH_GREEN] = pixels.green_in;
  assign s0_pixel[CH_BLUE]  = pixels.blue_in;

  always_comb begin
    s0_ctrl = '0;
    if (draining) begin
      s0_ctrl.drain  = 1'b1;
      s0_ctrl.first  = drain_pos == '0;
      s0_ctrl.rv     = {1'b0, 1'b1, height_eff >= HEIGHT_W'(2)};
      s0_ctrl.cv     = {!drain_end, 1'b1, drain_pos != '0};
      s0_ctrl.emit_a = 1'b1;
    end else begin
      s0_ctrl.rv     = {1'b1, 1'b1, row >= ROW_W'(2)};
      s0_ctrl.cv     = {1'b1, 1'b1, col >= AW'(2)};
      s0_ctrl.cvb0   = col != '0;
      s0_ctrl.emit_a = (row != '0) && (col != '0);
      s0_ctrl.emit_b = (row != '0) && row_end;
      s0_ctrl.col0   = col == '0;
    end
    if (is_flush) begin
      nres = 2'd1;
    end else if (is_pix) begin
      nres = 2'(s0_ctrl.emit_a) + 2'(s0_ctrl.emit_b);
    end else begin
      nres = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      drain_pos <= '0;
      draining  <= 1'b0;
    end else if (accept) begin
      if (is_flush) begin
        if (drain_end) begin
          draining  <= 1'b0;
          drain_pos <= '0;
          col       <= '0;
          row       <= '0;
        end else begin
          drain_pos <= drain_p1[AW-1:0];
        end
      end else if (is_pix) begin
        if (row_end) begin
          col <= '0;
          if (frame_end) begin
            draining  <= 1'b1;
            drain_pos <= '0;
            row       <= '0;
          end else begin
            row <= row_p1[ROW_W-1:0];
          end
        end else begin
          col <= col_p1[AW-1:0];
        end
      end
    end
  end

  assign pop = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= RES_CNT_W'(RES_DEPTH);
    end else begin
      credits <= credits - (accept ? RES_CNT_W'(nres) : '0) + RES_CNT_W'(pop);
    end
  end

  bb3_line_store #(
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (s0_valid),
    .rd_addr (s0_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bb3_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .s0_valid (s0_valid),
    .s0_ctrl  (s0_ctrl),
    .s0_addr  (s0_addr),
    .s0_pixel (s0_pixel),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .s2_valid (s2_valid),
    .s2_slot  (s2_slot)
  );

  bb3_divide u_divide (
    .slot (s2_slot),
    .res  (res)
  );

  bb3_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .din       (res),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .dout      (head)
  );

  assign results.red_out     = head.mean[CH_RED];
  assign results.green_out   = head.mean[CH_GREEN];
  assign results.blue_out    = head.mean[CH_BLUE];
  assign results.last_of_run = head.last;

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits <= RES_CNT_W'(RES_DEPTH))
    else $error("result credits above queue depth");

  a_drain_counters: assert property (@(posedge clk) disable iff (rst)
    draining |-> (col == '0) && (row == '0))
    else $error("row or column counter moved during drain");

  a_drain_exit: assert property (@(posedge clk) disable iff (rst)
    (accept && is_flush && drain_end) |=> !draining && (drain_pos == '0))
    else $error("drain did not end after the last flush beat");

endmodule
